// File: hdl/adpcm_pkg.sv
`default_nettype none

package adpcm_pkg;

  // Datapath widths.
  localparam int unsigned LEVEL_WIDTH = 20;
  localparam int unsigned STEP_WIDTH  = 16;
  localparam int unsigned DIFF_WIDTH  = LEVEL_WIDTH + 1;
  localparam int unsigned CMP_WIDTH   = (DIFF_WIDTH > STEP_WIDTH) ? DIFF_WIDTH : STEP_WIDTH;
  localparam int unsigned MULT_WIDTH  = 15;
  localparam int unsigned PROD_WIDTH  = STEP_WIDTH + 4;
  localparam int unsigned SPROD_WIDTH = STEP_WIDTH + MULT_WIDTH;
  localparam int unsigned SUM_WIDTH   =
      ((LEVEL_WIDTH > PROD_WIDTH) ? LEVEL_WIDTH : PROD_WIDTH) + 2;
  localparam int unsigned STEP_SHIFT  = 14;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Code widths.
  localparam logic [2:0] CODE_BITS_MIN   = 3'd2;
  localparam logic [2:0] CODE_BITS_MAX   = 3'd4;
  localparam logic [2:0] CODE_BITS_RESET = 3'd4;
  localparam logic [3:0] ZERO_CODE_4BIT  = 4'd8;

  // Step size limits and rounding.
  localparam logic [STEP_WIDTH-1:0]  STEP_MIN   = STEP_WIDTH'(5);
  localparam logic [STEP_WIDTH-1:0]  STEP_MAX   = {STEP_WIDTH{1'b1}};
  localparam logic [SPROD_WIDTH:0]   STEP_ROUND = (SPROD_WIDTH + 1)'(32'h2000);

  // Predicted level limits.
  localparam logic signed [SUM_WIDTH-1:0] LEVEL_MAX =
      SUM_WIDTH'((64'sd1 <<< (LEVEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_WIDTH-1:0] LEVEL_MIN =
      SUM_WIDTH'(-(64'sd1 <<< (LEVEL_WIDTH - 1)));

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  // An accepted item together with the code width that applies to it.
  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
    logic [2:0] nb;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QUANT,
    BK_MULT,
    BK_WB,
    BK_EMIT
  } back_state_e;

  // Step multiplier for a given code width and magnitude.
  function automatic logic [MULT_WIDTH-1:0] mult_lookup(input logic [2:0] nb,
                                                        input logic [2:0] mag);
    logic [MULT_WIDTH-1:0] m;
    m = '0;
    case (nb)
      3'd2: begin
        m = mag[0] ? MULT_WIDTH'(16'h5600) : MULT_WIDTH'(16'h3800);
      end
      3'd3: begin
        case (mag[1:0])
          2'd0:    m = MULT_WIDTH'(16'h399a);
          2'd1:    m = MULT_WIDTH'(16'h3a9f);
          2'd2:    m = MULT_WIDTH'(16'h4d14);
          default: m = MULT_WIDTH'(16'h6607);
        endcase
      end
      default: begin
        case (mag)
          3'd0:    m = MULT_WIDTH'(16'h3556);
          3'd1:    m = MULT_WIDTH'(16'h3556);
          3'd2:    m = MULT_WIDTH'(16'h399a);
          3'd3:    m = MULT_WIDTH'(16'h3a9f);
          3'd4:    m = MULT_WIDTH'(16'h4200);
          3'd5:    m = MULT_WIDTH'(16'h4d14);
          default: m = MULT_WIDTH'(16'h6607);
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/adpcm_front.sv
`default_nettype none

module adpcm_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire adpcm_pkg::in_item_t  in_item_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_wdata_i,
  output logic                      q_push_o,
  output adpcm_pkg::job_t           q_job_o,
  input  wire logic                 q_full_i
);
  import adpcm_pkg::*;

  logic [2:0] code_bits_q;
  logic       slot_valid_q, slot_valid_d;
  job_t       slot_q, slot_d;
  logic [2:0] nb_eff;
  logic       accept;

  // Codes below two bits act as two, above four as four.
  always_comb begin
    if (code_bits_q < CODE_BITS_MIN) begin
      nb_eff = CODE_BITS_MIN;
    end else if (code_bits_q > CODE_BITS_MAX) begin
      nb_eff = CODE_BITS_MAX;
    end else begin
      nb_eff = code_bits_q;
    end
  end

  assign full     = slot_valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = slot_valid_q;
  assign q_job_o  = slot_q;

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_d       = slot_q;
    if (accept) begin
      slot_valid_d       = 1'b1;
      slot_d.sample      = in_item_i.sample;
      slot_d.last_sample = in_item_i.last_sample;
      slot_d.nb          = nb_eff;
    end else if (slot_valid_q && !q_full_i) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q  <= CODE_BITS_RESET;
      slot_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        code_bits_q <= cfg_wdata_i;
      end
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// File: hdl/adpcm_queue.sv
`default_nettype none

module adpcm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire adpcm_pkg::job_t  job_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output adpcm_pkg::job_t       job_o,
  output logic                  empty_o
);
  import adpcm_pkg::*;

  job_t                  entry_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_WIDTH-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_WIDTH-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/adpcm_back.sv
`default_nettype none

module adpcm_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire adpcm_pkg::job_t  job_i,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  output logic                  empty,
  input  wire logic             pop,
  output adpcm_pkg::out_item_t  out_item_o
);
  import adpcm_pkg::*;

  back_state_e state_q, state_d;

  // Persistent encoder state.
  logic signed [LEVEL_WIDTH-1:0] level_q, level_d;
  logic [STEP_WIDTH-1:0]         step_q, step_d;
  logic [11:0]                   acc_q, acc_d;
  logic [2:0]                    pend_q, pend_d;

  // Per-item working registers.
  logic [2:0]             nb_q, nb_d;
  logic                   last_q, last_d;
  logic [CMP_WIDTH-1:0]   delta_q, delta_d;
  logic [3:0]             code_q, code_d;
  logic [2:0]             left_q, left_d;
  logic                   neg_q, neg_d;
  logic [PROD_WIDTH-1:0]  prod_q, prod_d;
  logic [SPROD_WIDTH-1:0] sprod_q, sprod_d;
  logic [7:0]             byte0_q, byte0_d, byte1_q, byte1_d;
  logic [1:0]             nbytes_q, nbytes_d;
  logic                   emit_q, emit_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // Combinational helpers.
  logic signed [DIFF_WIDTH-1:0]  diff, diff_abs;
  logic [3:0]                    half;
  logic                          sub_ok;
  logic                          neg_now;
  logic [2:0]                    mag;
  logic [11:0]                   acc1, acc2;
  logic [3:0]                    p1;
  logic                          got1, flush;
  logic [2:0]                    pr;
  logic [3:0]                    fill;
  logic [7:0]                    byte_a, byte_f;
  logic [PROD_WIDTH:0]           prod_inc;
  logic signed [SUM_WIDTH-1:0]   adj, lvl_sum;
  logic [SPROD_WIDTH:0]          srnd;
  logic [SPROD_WIDTH-STEP_SHIFT:0] step_new;
  logic                          out_free;
  logic                          emit_last;

  assign out_free  = !out_valid_q || pop;
  assign emit_last = ({1'b0, emit_q} == (nbytes_q - 2'd1));
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  assign half   = 4'(4'd1 << (nb_q - 3'd1));
  assign sub_ok = (left_q != 3'd0) && (delta_q > CMP_WIDTH'(step_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = BK_QUANT;
        end
      end
      BK_QUANT: begin
        if (!sub_ok) begin
          state_d = BK_MULT;
        end
      end
      BK_MULT: begin
        state_d = BK_WB;
      end
      BK_WB: begin
        state_d = (nbytes_q != 2'd0) ? BK_EMIT : BK_IDLE;
      end
      BK_EMIT: begin
        if (out_free && emit_last) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    level_d     = level_q;
    step_d      = step_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    nb_d        = nb_q;
    last_d      = last_q;
    delta_d     = delta_q;
    code_d      = code_q;
    left_d      = left_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    sprod_d     = sprod_q;
    byte0_d     = byte0_q;
    byte1_d     = byte1_q;
    nbytes_d    = nbytes_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;

    diff = $signed({{(DIFF_WIDTH - 14){1'b0}}, job_i.sample, 6'b0}) - DIFF_WIDTH'(level_q);
    diff_abs = diff[DIFF_WIDTH-1] ? -diff : diff;

    neg_now = |(code_q & half);
    mag     = 3'(code_q & (half - 4'd1));

    acc1   = 12'((acc_q << nb_q) | 12'(code_q));
    p1     = {1'b0, pend_q} + {1'b0, nb_q};
    got1   = (p1 >= 4'd8);
    byte_a = 8'(acc1 >> (p1 - 4'd8));
    pr     = got1 ? 3'(p1 - 4'd8) : 3'(p1);
    flush  = last_q && (pr != 3'd0);
    fill   = 4'd8 - {1'b0, pr};
    acc2   = 12'(acc1 << fill);
    byte_f = acc2[7:0];

    prod_inc = {1'b0, prod_q} + 1'b1;
    adj = neg_q ? -$signed(SUM_WIDTH'(prod_inc[PROD_WIDTH:1]))
                :  $signed(SUM_WIDTH'(prod_q[PROD_WIDTH-1:1]));
    lvl_sum = SUM_WIDTH'(level_q) + adj + $signed(SUM_WIDTH'(step_q[0]));

    srnd     = {1'b0, sprod_q} + STEP_ROUND;
    step_new = srnd[SPROD_WIDTH:STEP_SHIFT];

    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          nb_d    = job_i.nb;
          last_d  = job_i.last_sample;
          delta_d = CMP_WIDTH'(unsigned'(diff_abs));
          code_d  = diff[DIFF_WIDTH-1] ? 4'(4'd1 << (job_i.nb - 3'd1)) : 4'd0;
          left_d  = 3'((4'd1 << (job_i.nb - 3'd1)) - 4'd1);
        end
      end
      BK_QUANT: begin
        if (sub_ok) begin
          delta_d = delta_q - CMP_WIDTH'(step_q);
          code_d  = code_q + 4'd1;
          left_d  = left_q - 3'd1;
        end else if ((nb_q == CODE_BITS_MAX) && (code_q == 4'd0)) begin
          // A positive zero is sent with the sign bit set in 4-bit mode.
          code_d = ZERO_CODE_4BIT;
        end
      end
      BK_MULT: begin
        neg_d   = neg_now;
        prod_d  = PROD_WIDTH'({mag, 1'b1}) * PROD_WIDTH'(step_q);
        sprod_d = SPROD_WIDTH'(step_q) * SPROD_WIDTH'(mult_lookup(nb_q, mag));
        if (got1) begin
          byte0_d = byte_a;
          byte1_d = byte_f;
        end else begin
          byte0_d = byte_f;
          byte1_d = byte_f;
        end
        nbytes_d = {1'b0, got1} + {1'b0, flush};
        acc_d    = flush ? acc2 : acc1;
        pend_d   = flush ? 3'd0 : pr;
        emit_d   = 1'b0;
      end
      BK_WB: begin
        if (lvl_sum > LEVEL_MAX) begin
          level_d = LEVEL_WIDTH'(LEVEL_MAX);
        end else if (lvl_sum < LEVEL_MIN) begin
          level_d = LEVEL_WIDTH'(LEVEL_MIN);
        end else begin
          level_d = LEVEL_WIDTH'(lvl_sum);
        end
        if (step_new < (SPROD_WIDTH - STEP_SHIFT + 1)'(STEP_MIN)) begin
          step_d = STEP_MIN;
        end else if (step_new > (SPROD_WIDTH - STEP_SHIFT + 1)'(STEP_MAX)) begin
          step_d = STEP_MAX;
        end else begin
          step_d = STEP_WIDTH'(step_new);
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.code_byte  = emit_q ? byte1_q : byte0_q;
          out_d.run_last   = emit_last;
          out_d.stream_end = emit_last && last_q;
          emit_d           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      level_q     <= '0;
      step_q      <= STEP_MIN;
      acc_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q     <= nb_d;
    last_q   <= last_d;
    delta_q  <= delta_d;
    code_q   <= code_d;
    left_q   <= left_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    sprod_q  <= sprod_d;
    byte0_q  <= byte0_d;
    byte1_q  <= byte1_d;
    nbytes_q <= nbytes_d;
    emit_q   <= emit_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// File: hdl/adpcm_audio_encoder_unit.sv
`default_nettype none

// ADPCM audio encoder. Each item is one unsigned 8-bit linear sample; the
// block turns it into a 2-, 3- or 4-bit adaptive code (chosen by the code
// width register, which resets to 4) and packs the codes most significant
// bit first into bytes. An item yields zero, one or two result bytes. The
// final byte caused by an item carries run_last, and when the item is marked
// last_sample the remaining bits are flushed with zero padding and that final
// byte also carries stream_end; a last sample with nothing left to flush adds
// no byte. The predicted level and step size carry on across streams and are
// cleared only by reset. Write the code width only while the block is idle.
// The back end handles one item at a time. Its quantiser takes at most 1, 3
// or 7 step subtractions for 2-, 3- or 4-bit codes, one subtraction per
// cycle; then come the multiply and packing step, the level and step
// write-back and the emission of 0 to 2 bytes, each of which waits while
// the output register is still full. Up to three further items are taken in
// while the back end is busy: one in the input register and two in the
// queue behind it. A finished byte waits in the output register while the
// next item is being worked on.

module adpcm_audio_encoder_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire adpcm_pkg::in_item_t  in_item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output adpcm_pkg::out_item_t      out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_wdata_i
);
  import adpcm_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t front_job;
  job_t back_job;

  // Front end: takes items in, holds the code width register and tags each
  // item with the code width that applies to it.
  adpcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_push_o    (q_push),
    .q_job_o     (front_job),
    .q_full_i    (q_full)
  );

  // Short queue that lets the front end keep taking items while the back end
  // is still quantising.
  adpcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (back_job),
    .empty_o (q_empty)
  );

  // Back end: quantiser, level and step update, bit packer and output
  // register.
  adpcm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (back_job),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
